// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with error report.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package u8d_pkg;

	// Result kinds (carried on m_tuser)
	localparam logic [1:0] KIND_CODE  = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_INCOMPLETE  = 3'd0;
	localparam logic [2:0] ERR_CONT_MISS   = 3'd1;
	localparam logic [2:0] ERR_OVERLONG    = 3'd2;
	localparam logic [2:0] ERR_CONT_UNEXP  = 3'd3;
	localparam logic [2:0] ERR_INVALID     = 3'd4;

	// Overlong limits and the byte order mark
	localparam logic [20:0] MIN_2B = 21'h00080;
	localparam logic [20:0] MIN_3B = 21'h00800;
	localparam logic [20:0] MIN_4B = 21'h10000;
	localparam logic [20:0] BOM_CP = 21'h0FEFF;

	localparam int OUT_OFF_W = 32;

	// One result transaction
	typedef struct packed {
		logic [1:0]           kind;
		logic [20:0]          code;
		logic [2:0]           len;
		logic [2:0]           err;
		logic [OUT_OFF_W-1:0] offset;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // write accepted byte into window
		logic step;      // apply current window evaluation
		logic end_mark;  // load end marker, clear window
		logic push;      // move pending result to output register
		logic push_last; // pushed result closes the run
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stop;       // evaluation needs more bytes or window empty
		logic emit;       // evaluation yields a result
		logic last;       // current input carried the stream end flag
		logic pend_valid; // pending result held
		logic out_free;   // output register can take a result
	} dp_status_t;

endpackage

// ===== rtl/utf8_decoder_with_error_report_unit.sv =====
// Top level of the UTF-8 decoder with error report.
// Instantiates u8d_ctrl and u8d_datapath; depends on u8d_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream takes one encoded byte per transaction (s_tdata), s_tlast
//   marks the final byte of a stream. Master stream returns results: code
//   points, error reports and an end marker (kind on m_tuser). m_tlast is
//   set on the last result caused by an input byte; a byte may cause none.
//   Flow: each byte is loaded in the idle state, then the scan state takes
//   one window scan step per code point, error or dropped byte order
//   mark, the final byte adds the end marker state, and a flush state ends
//   the byte; no new byte is taken until then. Scanning, one sequence per
//   cycle, stalls while the pending and output registers are both full.
//   A result passes through the pending and then the output register.
//   Reset clears the window, the stream offset and both handshakes; the
//   byte window contents are not cleared. After the final byte the block
//   returns to the reset state on its own for the next stream.
//   When m_tready is low, one result waits in the output register and one
//   more in the pending register; scanning then stalls and s_tready stays
//   low until the current byte is fully processed.
//
module utf8_decoder_with_error_report_unit import u8d_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [20:0] code_value, [23:21] seq_length,
	                              // [26:24] error_code, [58:27] byte_offset
	output logic [1:0]  m_tuser,  // [1:0] result_kind
	output logic        m_tlast   // run_last
);

	dp_cmd_t    cmd;
	dp_status_t st;
	result_t    res;

	u8d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	u8d_datapath #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	// Pack result fields, lowest first
	assign m_tdata = {5'd0, res.offset, res.err, res.len, res.code};
	assign m_tuser = res.kind;

endmodule

// ===== rtl/u8d_ctrl.sv =====
// Controller state machine for the UTF-8 decoder.
// Depends on u8d_pkg for command and status types.
`timescale 1ns / 1ps

module u8d_ctrl import u8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_ENDMK = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.stop) begin
					state_d = st.last ? ST_ENDMK : ST_FLUSH;
				end else if (!st.emit) begin
					cmd.step = 1'b1;
				end else if (!st.pend_valid || st.out_free) begin
					cmd.step = 1'b1;
					cmd.push = st.pend_valid;
				end
			end
			ST_ENDMK: begin
				if (!st.pend_valid || st.out_free) begin
					cmd.end_mark = 1'b1;
					cmd.push     = st.pend_valid;
					state_d      = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!st.pend_valid) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/u8d_datapath.sv =====
// Datapath of the UTF-8 decoder: byte window, sequence evaluation,
// pending result and output register. Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_datapath import u8d_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  st,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     out_res,
	output logic        out_last
);

	logic [7:0]             win_q [4];
	logic [2:0]             fill_q;
	logic [OFFSET_BITS-1:0] head_q;
	logic                   last_q;
	result_t                pend_q;
	logic                   pend_valid_q;
	result_t                out_q;
	logic                   out_valid_q;
	logic                   out_last_q;

	logic [7:0]  b0, b1, b2, b3;
	logic [2:0]  need;
	logic        cont_ok;
	logic        overlong;
	logic [20:0] cp;
	logic        ev_stop;
	logic        ev_emit;
	logic [2:0]  ev_drop;
	result_t     ev_res;
	result_t     end_res;
	logic [OFFSET_BITS+OUT_OFF_W-1:0] off_ext;
	logic        out_free;

	assign b0 = win_q[0];
	assign b1 = win_q[1];
	assign b2 = win_q[2];
	assign b3 = win_q[3];
	assign off_ext = {{OUT_OFF_W{1'b0}}, head_q};
	assign out_free = !out_valid_q || out_ready;

	// Lead class, continuation check and code point assembly
	always_comb begin
		need = 3'd0;
		cp   = '0;
		if (!b0[7]) begin
			need = 3'd1;
			cp   = {14'd0, b0[6:0]};
		end else if (b0[7:5] == 3'b110) begin
			need = 3'd2;
			cp   = {10'd0, b0[4:0], b1[5:0]};
		end else if (b0[7:4] == 4'b1110) begin
			need = 3'd3;
			cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
		end else if (b0[7:3] == 5'b11110) begin
			need = 3'd4;
			cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
		end
		cont_ok = (need < 3'd2 || b1[7:6] == 2'b10)
			&& (need < 3'd3 || b2[7:6] == 2'b10)
			&& (need < 3'd4 || b3[7:6] == 2'b10);
		overlong = (need == 3'd2 && cp < MIN_2B)
			|| (need == 3'd3 && cp < MIN_3B)
			|| (need == 3'd4 && cp < MIN_4B);
	end

	// Judge the sequence at the window head
	always_comb begin
		ev_stop       = 1'b0;
		ev_emit       = 1'b1;
		ev_drop       = 3'd1;
		ev_res        = '0;
		ev_res.kind   = KIND_ERROR;
		ev_res.offset = off_ext[OUT_OFF_W-1:0];
		priority if (fill_q == 3'd0) begin
			ev_stop = 1'b1;
			ev_emit = 1'b0;
		end else if (b0[7:6] == 2'b10) begin
			ev_res.err = ERR_CONT_UNEXP;
		end else if (need == 3'd0) begin
			ev_res.err = ERR_INVALID;
		end else if (need > fill_q) begin
			if (!last_q) begin
				ev_stop = 1'b1;
				ev_emit = 1'b0;
			end
			ev_res.err = ERR_INCOMPLETE;
		end else if (!cont_ok) begin
			ev_res.err = ERR_CONT_MISS;
		end else if (overlong) begin
			ev_res.err = ERR_OVERLONG;
		end else begin
			ev_drop     = need;
			ev_res.kind = KIND_CODE;
			ev_res.code = cp;
			ev_res.len  = need;
			// leading byte order mark is dropped silently
			ev_emit = !(head_q == '0 && need == 3'd3 && cp == BOM_CP);
		end
	end

	// End marker carries the stream length
	always_comb begin
		end_res        = '0;
		end_res.kind   = KIND_END;
		end_res.offset = off_ext[OUT_OFF_W-1:0];
	end

	// Window bytes hold no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (fill_q < 3'd4) begin
				win_q[fill_q[1:0]] <= in_byte;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) + ev_drop < 3'd4) begin
					win_q[i] <= win_q[2'(3'(i) + ev_drop)];
				end
			end
		end
	end

	// Window fill, head offset, stream end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
			last_q <= 1'b0;
		end else if (cmd.load) begin
			last_q <= in_last;
			if (fill_q < 3'd4) begin
				fill_q <= fill_q + 3'd1;
			end
		end else if (cmd.step) begin
			fill_q <= fill_q - ev_drop;
			head_q <= head_q + OFFSET_BITS'(ev_drop);
		end else if (cmd.end_mark) begin
			fill_q <= '0;
			head_q <= '0;
			last_q <= 1'b0;
		end
	end

	// Pending result: held until it is known whether another follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if ((cmd.step && ev_emit) || cmd.end_mark) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && ev_emit) begin
			pend_q <= ev_res;
		end else if (cmd.end_mark) begin
			pend_q <= end_res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q      <= pend_q;
			out_last_q <= cmd.push_last;
		end
	end

	assign st.stop       = ev_stop;
	assign st.emit       = ev_emit;
	assign st.last       = last_q;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

// ===== bench/utf8_decode_checker.sv =====
// Scoreboard for the UTF-8 decoder: watches both stream channels, predicts the
// results of every accepted byte and compares them with what the block returns.
// Depends on u8d_pkg for result kinds, error codes and decode limits.
`timescale 1ns / 1ps

module utf8_decode_checker import u8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // stream_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,  // [20:0] code_value, [23:21] seq_length,
	                              // [26:24] error_code, [58:27] byte_offset
	input  logic [1:0]  m_tuser,  // [1:0] result_kind
	input  logic        m_tlast,  // run_last
	output int          mismatches,
	output int          outstanding,
	output int          results_checked
);

	typedef struct {
		logic [1:0]  kind;
		logic [20:0] code;
		logic [2:0]  len;
		logic [2:0]  err;
		logic [31:0] offset;
		logic        run_last;
	} decoded_t;

	decoded_t    decoded_q[$];
	logic [7:0]  win [4];
	int unsigned fill;
	logic [31:0] head;
	int          fail_count;
	int          seen_count;

	// Queue one expected result at the current head of the window
	function automatic void note_result(input logic [1:0] kind, input logic [20:0] code,
			input logic [2:0] len, input logic [2:0] err);
		decoded_t r;
		r.kind = kind;
		r.code = code;
		r.len = len;
		r.err = err;
		r.offset = head;
		r.run_last = 1'b0;
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	// Retire n bytes from the front of the window
	function automatic void retire_bytes(input int unsigned n);
		int unsigned k;
		if (n > fill)
			n = fill;
		for (k = 0; k + n < 4; k++)
			win[k] = win[k + n];
		fill = fill - n;
		head = head + n;
	endfunction

	// Expected results of one accepted byte
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		int          first;
		int unsigned need;
		int unsigned i;
		logic [7:0]  lead;
		logic [20:0] cp;
		logic [20:0] lower;
		bit          ok;
		bit          wait_more;
		first = decoded_q.size();
		wait_more = 1'b0;
		if (fill < 4) begin
			win[fill] = b;
			fill++;
		end
		while (fill > 0 && !wait_more) begin
			lead = win[0];
			need = 0;
			cp = '0;
			lower = '0;
			if (lead[7] == 1'b0) begin
				need = 1;
				cp = {14'd0, lead[6:0]};
			end else if (lead[7:5] == 3'b110) begin
				need = 2;
				cp = {16'd0, lead[4:0]};
				lower = MIN_2B;
			end else if (lead[7:4] == 4'b1110) begin
				need = 3;
				cp = {17'd0, lead[3:0]};
				lower = MIN_3B;
			end else if (lead[7:3] == 5'b11110) begin
				need = 4;
				cp = {18'd0, lead[2:0]};
				lower = MIN_4B;
			end
			if (need == 0) begin
				// stray continuation byte or a lead with five or more leading ones
				note_result(KIND_ERROR, '0, '0, lead[6] ? ERR_INVALID : ERR_CONT_UNEXP);
				retire_bytes(1);
			end else if (need > fill) begin
				if (!fin)
					wait_more = 1'b1;
				else begin
					note_result(KIND_ERROR, '0, '0, ERR_INCOMPLETE);
					retire_bytes(1);
				end
			end else begin
				ok = 1'b1;
				for (i = 1; i < need; i++) begin
					if (win[i][7:6] != 2'b10)
						ok = 1'b0;
					cp = (cp << 6) | {15'd0, win[i][5:0]};
				end
				if (!ok) begin
					note_result(KIND_ERROR, '0, '0, ERR_CONT_MISS);
					retire_bytes(1);
				end else if (cp < lower) begin
					note_result(KIND_ERROR, '0, '0, ERR_OVERLONG);
					retire_bytes(1);
				end else begin
					// byte order mark at the stream start is swallowed
					if (!(head == 0 && need == 3 && cp == BOM_CP))
						note_result(KIND_CODE, cp, need[2:0], '0);
					retire_bytes(need);
				end
			end
		end
		if (fin) begin
			note_result(KIND_END, '0, '0, '0);
			fill = 0;
			head = '0;
		end
		if (decoded_q.size() > first)
			decoded_q[decoded_q.size() - 1].run_last = 1'b1;
	endfunction

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
		end
	endtask

	// Predict on the input channel, compare on the output channel
	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			decoded_q.delete();
			for (int k = 0; k < 4; k++)
				win[k] = '0;
			fill = 0;
			head = '0;
			fail_count = 0;
			seen_count = 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				seen_count++;
				if (decoded_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result transaction, expected none, %s %0d data 0x%0h",
						$time, "actual kind", m_tuser, m_tdata);
				end else begin
					want = decoded_q.pop_front();
					compare_field("result_kind", {30'd0, want.kind}, {30'd0, m_tuser});
					compare_field("code_value", {11'd0, want.code}, {11'd0, m_tdata[20:0]});
					compare_field("seq_length", {29'd0, want.len}, {29'd0, m_tdata[23:21]});
					compare_field("error_code", {29'd0, want.err}, {29'd0, m_tdata[26:24]});
					compare_field("byte_offset", want.offset, m_tdata[58:27]);
					compare_field("tdata padding", 32'd0, {27'd0, m_tdata[63:59]});
					compare_field("run_last", {31'd0, want.run_last}, {31'd0, m_tlast});
				end
			end
		end
		mismatches <= fail_count;
		outstanding <= decoded_q.size();
		results_checked <= seen_count;
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the UTF-8 decoder regression: clock, reset, byte stimulus and stalls.
// Instantiates utf8_decoder_with_error_report_unit and utf8_decode_checker.
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET = 270;
	localparam int QUIET_FROM  = 210;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int          mismatches;
	int          outstanding;
	int          results_checked;
	int          bytes_sent;
	int          streams_sent;
	int          cycles;
	bit          send_gaps;
	bit          recv_stalls;
	bit          pressure_done;
	logic [7:0]  stream_bytes[$];

	utf8_decoder_with_error_report_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	utf8_decode_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run guard
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("utf8_decoder_with_error_report_unit regression: fail");
		$finish;
	end

	// Receiver backpressure in random bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (recv_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic int code_floor(input int len);
		case (len)
			2: return 32'h80;
			3: return 32'h800;
			default: return 32'h10000;
		endcase
	endfunction

	function automatic int code_ceiling(input int len);
		case (len)
			2: return 32'h7FF;
			3: return 32'hFFFF;
			default: return 32'h1FFFFF;
		endcase
	endfunction

	// Append one byte to the stream under construction
	function automatic void add_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endfunction

	// Encode cp in len bytes, no check that it fits the shortest form
	function automatic void put_code(input logic [20:0] cp, input int len);
		case (len)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Mostly well-formed sequences; some truncated, overlong or plain noise
	function automatic void add_sequence();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		if (pick < 25)
			put_code(21'($urandom_range(0, 127)), 1);
		else if (pick < 72)
			put_code(21'($urandom_range(code_floor(len), code_ceiling(len))), len);
		else if (pick < 82) begin
			put_code(21'($urandom_range(code_floor(len), code_ceiling(len))), len);
			repeat ($urandom_range(1, len - 1)) void'(stream_bytes.pop_back());
		end else if (pick < 89)
			put_code(21'($urandom_range(0, code_floor(len) - 1)), len);
		else if (pick < 94)
			add_byte({2'b10, 6'($urandom_range(0, 63))});
		else
			add_byte(8'($urandom_range(0, 255)));
	endfunction

	// One byte transaction; leaves s_tvalid high at the next falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		streams_sent++;
	endtask

	// Stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		pressure_done = 1'b0;
		bytes_sent = 0;
		streams_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Opening stream: mark at offset zero, ASCII zero, every error kind,
		// all lengths, the largest value, and a short sequence at the end
		stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'hFF, 8'h80, 8'hC3, 8'h41,
			8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF,
			8'hBF, 8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'hE2, 8'h82};
		send_stream();

		// Random streams
		while (bytes_sent < ITEM_TARGET) begin
			if (!pressure_done && bytes_sent >= ITEM_TARGET / 2) begin
				// let the block drain completely before going on
				pressure_done = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
				@(negedge clk);
			end
			if (bytes_sent >= QUIET_FROM) begin
				send_gaps = 1'b0;
				recv_stalls = 1'b0;
			end else begin
				send_gaps = $urandom_range(0, 3) != 0;
				recv_stalls = $urandom_range(0, 3) != 0;
			end
			stream_bytes.delete();
			if ($urandom_range(0, 4) == 0)
				put_code(21'h0FEFF, 3);
			repeat ($urandom_range(1, 8)) add_sequence();
			send_stream();
		end
		s_tvalid <= 1'b0;

		// Drain, then keep watching for anything stray
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d streams: valid 1-4 byte codes, marks, truncated,",
			bytes_sent, streams_sent);
		$display("overlong and stray bytes, with random gaps and stalls; %0d results checked",
			results_checked);
		if (mismatches == 0)
			$display("utf8_decoder_with_error_report_unit regression: pass");
		else
			$display("utf8_decoder_with_error_report_unit regression: fail");
		$finish;
	end

endmodule
